[rtl/core/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, constants and helpers for the pressure compensation pipeline
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DIV_W = 32;   // quotient bits, one divider stage per bit

    // register indexes of the configuration port
    localparam logic [2:0] REG_CAL_A    = 3'd0;
    localparam logic [2:0] REG_CAL_B    = 3'd1;
    localparam logic [2:0] REG_CAL_QUAD = 3'd2;
    localparam logic [2:0] REG_CAL_TEMP = 3'd3;
    localparam logic [2:0] REG_OSS      = 3'd4;

    // everything one sample pair carries down the pipeline
    typedef struct packed {
        logic [15:0]        ut;
        logic [18:0]        up;
        logic signed [31:0] p1;
        logic signed [31:0] x1;
        logic signed [31:0] den;
        logic signed [31:0] num;
        logic               sgn;
        logic               den0;
        logic signed [31:0] b5;
        logic signed [31:0] t;
        logic signed [31:0] b6;
        logic signed [31:0] sqp;
        logic signed [31:0] pac2;
        logic signed [31:0] pac3;
        logic signed [31:0] sq;
        logic signed [31:0] x2a;
        logic signed [31:0] x1c;
        logic signed [31:0] mb2;
        logic signed [31:0] mb1;
        logic signed [31:0] x3;
        logic signed [31:0] x3c;
        logic signed [31:0] b3;
        logic [31:0]        b4p;
        logic [31:0]        b4;
        logic [31:0]        b7;
        logic               b4z;
        logic               big;
        logic signed [31:0] p;
        logic signed [31:0] q;
        logic signed [31:0] m2;
        logic signed [31:0] qq;
        logic signed [31:0] x2p;
        logic signed [31:0] x1b;
        logic signed [31:0] pout;
        logic               err;
    } pipe_t;

    // signed division by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                     input int unsigned k);
        logic signed [31:0] bias;
        bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (v + bias) >>> k;
    endfunction

endpackage

[rtl/core/bpc_div.sv]
// ----------------------------------------------------------------------------
// bpc_div
// pipelined 32 by 32 unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       in_num,
    input  logic [31:0]       in_den,
    input  bpc_pkg::pipe_t    in_pay,
    output logic              out_valid,
    output logic [31:0]       out_quot,
    output bpc_pkg::pipe_t    out_pay
);

    localparam int N = bpc_pkg::DIV_W;

    logic [31:0]    rem_reg  [1:N];
    logic [31:0]    num_reg  [1:N];
    logic [31:0]    den_reg  [1:N];
    logic [31:0]    quot_reg [1:N];
    bpc_pkg::pipe_t pay_reg  [1:N];
    logic [N:1]     vld_reg;

    logic [31:0]    rem_next  [1:N];
    logic [31:0]    num_next  [1:N];
    logic [31:0]    quot_next [1:N];

    // operands seen by each stage: the ports for the first, the previous stage otherwise
    logic [31:0]    rem_src  [1:N];
    logic [31:0]    num_src  [1:N];
    logic [31:0]    den_src  [1:N];
    logic [31:0]    quot_src [1:N];

    always_comb
    begin
        rem_src[1]  = '0;
        num_src[1]  = in_num;
        den_src[1]  = in_den;
        quot_src[1] = '0;
        for (int k = 2; k <= N; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            num_src[k]  = num_reg[k-1];
            den_src[k]  = den_reg[k-1];
            quot_src[k] = quot_reg[k-1];
        end
    end

    always_comb
    begin
        logic [32:0] sh;
        for (int k = 1; k <= N; k++)
        begin
            sh = {rem_src[k], num_src[k][31]};
            if (sh >= {1'b0, den_src[k]})
            begin
                sh           = sh - {1'b0, den_src[k]};
                quot_next[k] = {quot_src[k][30:0], 1'b1};
            end
            else
            begin
                quot_next[k] = {quot_src[k][30:0], 1'b0};
            end
            rem_next[k] = sh[31:0];
            num_next[k] = {num_src[k][30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[1] <= in_pay;
            for (int k = 1; k <= N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_next[k];
                quot_reg[k] <= quot_next[k];
                den_reg[k]  <= den_src[k];
            end
            for (int k = 2; k <= N; k++)
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quot  = quot_reg[N];
    assign out_pay   = pay_reg[N];

endmodule

[rtl/core/barometer_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// barometer_pressure_compensation
// integer temperature and pressure compensation for a digital barometer
// ----------------------------------------------------------------------------
// One raw temperature / raw pressure pair enters per beat and one result beat
// leaves after passing through 4 front stages, a 32-stage divider for the
// temperature term, 9 middle stages, a 32-stage divider for the pressure
// quotient and 5 tail stages, the last of which is the output register.
// A new pair is taken every cycle; the only thing that holds the pipeline is
// a result beat waiting at the output, which freezes every stage at once.
// A zero divisor in either division gives divide_error on tuser and zero
// data. Calibration words and oversampling come in over the APB port and
// must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // raw samples
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
    // compensated results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // temperature_tenths[31:0], pressure_pascal[63:32]
    output logic        m_axis_tuser    // divide_error
);

    // configuration registers
    logic [47:0] cal_a_reg;
    logic [47:0] cal_b_reg;
    logic [31:0] cal_quad_reg;
    logic [31:0] cal_temp_reg;
    logic [1:0]  oss_reg;

    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg    <= '0;
            cal_b_reg    <= '0;
            cal_quad_reg <= '0;
            cal_temp_reg <= '0;
            oss_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bpc_pkg::REG_CAL_A:    cal_a_reg    <= pwdata[47:0];
                bpc_pkg::REG_CAL_B:    cal_b_reg    <= pwdata[47:0];
                bpc_pkg::REG_CAL_QUAD: cal_quad_reg <= pwdata[31:0];
                bpc_pkg::REG_CAL_TEMP: cal_temp_reg <= pwdata[31:0];
                bpc_pkg::REG_OSS:      oss_reg      <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bpc_pkg::REG_CAL_A:    prdata = {16'd0, cal_a_reg};
            bpc_pkg::REG_CAL_B:    prdata = {16'd0, cal_b_reg};
            bpc_pkg::REG_CAL_QUAD: prdata = {32'd0, cal_quad_reg};
            bpc_pkg::REG_CAL_TEMP: prdata = {32'd0, cal_temp_reg};
            bpc_pkg::REG_OSS:      prdata = {62'd0, oss_reg};
            default:               prdata = '0;
        endcase
    end

    // calibration words, all but ac4 extended to 32 bits
    logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    logic [15:0]        ac4;

    assign ac1 = 32'(signed'(cal_a_reg[47:32]));
    assign ac2 = 32'(signed'(cal_a_reg[31:16]));
    assign ac3 = 32'(signed'(cal_a_reg[15:0]));
    assign ac4 = cal_b_reg[47:32];
    assign ac5 = $signed({16'd0, cal_b_reg[31:16]});
    assign ac6 = $signed({16'd0, cal_b_reg[15:0]});
    assign b1  = 32'(signed'(cal_quad_reg[31:16]));
    assign b2  = 32'(signed'(cal_quad_reg[15:0]));
    assign mc  = 32'(signed'(cal_temp_reg[31:16]));
    assign md  = 32'(signed'(cal_temp_reg[15:0]));

    // whole pipeline moves together, held only by a waiting output beat
    logic pipe_en;
    assign pipe_en       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    bpc_pkg::pipe_t pre_reg  [0:3];
    bpc_pkg::pipe_t pre_next [0:3];
    logic [3:0]     pre_vld_reg;
    bpc_pkg::pipe_t mid_reg  [0:8];
    bpc_pkg::pipe_t mid_next [0:8];
    logic [8:0]     mid_vld_reg;
    bpc_pkg::pipe_t tl_reg   [0:4];
    bpc_pkg::pipe_t tl_next  [0:4];
    logic [4:0]     tl_vld_reg;

    logic           d1_valid, d2_valid;
    logic [31:0]    d1_quot, d2_quot;
    bpc_pkg::pipe_t d1_pay, d2_pay;

    // front: temperature term up to the divider
    always_comb
    begin
        pre_next[0]    = pre_reg[0];
        pre_next[0].ut = s_axis_tdata[15:0];
        pre_next[0].up = s_axis_tdata[34:16];

        // (ut - ac6) * ac5
        pre_next[1]    = pre_reg[0];
        pre_next[1].p1 = ($signed({16'd0, pre_reg[0].ut}) - ac6) * ac5;

        pre_next[2]     = pre_reg[1];
        pre_next[2].x1  = bpc_pkg::sdiv_pow2(pre_reg[1].p1, 15);
        pre_next[2].den = bpc_pkg::sdiv_pow2(pre_reg[1].p1, 15) + md;
        pre_next[2].num = mc <<< 11;

        // magnitudes and sign for the unsigned divider
        pre_next[3]      = pre_reg[2];
        pre_next[3].num  = pre_reg[2].num[31] ? -pre_reg[2].num : pre_reg[2].num;
        pre_next[3].den  = pre_reg[2].den[31] ? -pre_reg[2].den : pre_reg[2].den;
        pre_next[3].sgn  = pre_reg[2].num[31] ^ pre_reg[2].den[31];
        pre_next[3].den0 = (pre_reg[2].den == 32'sd0);
    end

    bpc_div u_div_temp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (pre_vld_reg[3]),
        .in_num    ($unsigned(pre_reg[3].num)),
        .in_den    ($unsigned(pre_reg[3].den)),
        .in_pay    (pre_reg[3]),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_pay   (d1_pay)
    );

    // middle: temperature result and pressure terms up to the second divider
    always_comb
    begin
        logic signed [31:0] x2;
        x2 = d1_pay.sgn ? -$signed(d1_quot) : $signed(d1_quot);

        mid_next[0]    = d1_pay;
        mid_next[0].b5 = d1_pay.x1 + x2;

        mid_next[1]    = mid_reg[0];
        mid_next[1].t  = bpc_pkg::sdiv_pow2(mid_reg[0].b5 + 32'sd8, 4);
        mid_next[1].b6 = mid_reg[0].b5 - 32'sd4000;

        mid_next[2]      = mid_reg[1];
        mid_next[2].sqp  = mid_reg[1].b6 * mid_reg[1].b6;
        mid_next[2].pac2 = ac2 * mid_reg[1].b6;
        mid_next[2].pac3 = ac3 * mid_reg[1].b6;

        mid_next[3]     = mid_reg[2];
        mid_next[3].sq  = bpc_pkg::sdiv_pow2(mid_reg[2].sqp, 12);
        mid_next[3].x2a = bpc_pkg::sdiv_pow2(mid_reg[2].pac2, 11);
        mid_next[3].x1c = bpc_pkg::sdiv_pow2(mid_reg[2].pac3, 13);

        mid_next[4]     = mid_reg[3];
        mid_next[4].mb2 = b2 * mid_reg[3].sq;
        mid_next[4].mb1 = b1 * mid_reg[3].sq;

        mid_next[5]     = mid_reg[4];
        mid_next[5].x3  = bpc_pkg::sdiv_pow2(mid_reg[4].mb2, 11) + mid_reg[4].x2a;
        mid_next[5].x3c = bpc_pkg::sdiv_pow2(mid_reg[4].x1c
                          + bpc_pkg::sdiv_pow2(mid_reg[4].mb1, 16) + 32'sd2, 2);

        mid_next[6]     = mid_reg[5];
        mid_next[6].b3  = bpc_pkg::sdiv_pow2((((ac1 <<< 2) + mid_reg[5].x3) <<< oss_reg)
                          + 32'sd2, 2);
        mid_next[6].b4p = {16'd0, ac4} * $unsigned(mid_reg[5].x3c + 32'sd32768);

        mid_next[7]    = mid_reg[6];
        mid_next[7].b4 = mid_reg[6].b4p >> 15;
        mid_next[7].b7 = ({13'd0, mid_reg[6].up} - $unsigned(mid_reg[6].b3))
                         * (32'd50000 >> oss_reg);

        // keep the doubled dividend inside 32 bits
        mid_next[8]     = mid_reg[7];
        mid_next[8].b4z = (mid_reg[7].b4 == 32'd0);
        mid_next[8].big = mid_reg[7].b7[31];
        mid_next[8].b7  = mid_reg[7].b7[31] ? mid_reg[7].b7 : {mid_reg[7].b7[30:0], 1'b0};
    end

    bpc_div u_div_press
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (mid_vld_reg[8]),
        .in_num    (mid_reg[8].b7),
        .in_den    (mid_reg[8].b4),
        .in_pay    (mid_reg[8]),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_pay   (d2_pay)
    );

    // tail: final pressure correction, last stage is the output register
    always_comb
    begin
        tl_next[0]   = d2_pay;
        tl_next[0].p = d2_pay.big ? $signed({d2_quot[30:0], 1'b0}) : $signed(d2_quot);

        tl_next[1]    = tl_reg[0];
        tl_next[1].q  = bpc_pkg::sdiv_pow2(tl_reg[0].p, 8);
        tl_next[1].m2 = -32'sd7357 * tl_reg[0].p;

        tl_next[2]     = tl_reg[1];
        tl_next[2].qq  = tl_reg[1].q * tl_reg[1].q;
        tl_next[2].x2p = bpc_pkg::sdiv_pow2(tl_reg[1].m2, 16);

        tl_next[3]     = tl_reg[2];
        tl_next[3].x1b = tl_reg[2].qq * 32'sd3038;

        tl_next[4]      = tl_reg[3];
        tl_next[4].pout = tl_reg[3].p + bpc_pkg::sdiv_pow2(bpc_pkg::sdiv_pow2(tl_reg[3].x1b, 16)
                          + tl_reg[3].x2p + 32'sd3791, 4);
        tl_next[4].err  = tl_reg[3].den0 || tl_reg[3].b4z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            mid_vld_reg <= '0;
            tl_vld_reg  <= '0;
        end
        else if (pipe_en)
        begin
            pre_vld_reg <= {pre_vld_reg[2:0], s_axis_tvalid};
            mid_vld_reg <= {mid_vld_reg[7:0], d1_valid};
            tl_vld_reg  <= {tl_vld_reg[3:0], d2_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pre_reg[i] <= pre_next[i];
            end
            for (int i = 0; i < 9; i++)
            begin
                mid_reg[i] <= mid_next[i];
            end
            for (int i = 0; i < 5; i++)
            begin
                tl_reg[i] <= tl_next[i];
            end
        end
    end

    assign m_axis_tvalid = tl_vld_reg[4];
    assign m_axis_tuser  = tl_reg[4].err;
    assign m_axis_tdata  = tl_reg[4].err ? 64'd0
                                         : {tl_reg[4].pout, tl_reg[4].t};

`ifndef ASSERT_OFF
    // an error beat never carries data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("divide error beat with nonzero data");

    // a held output freezes the valid bits of the front, middle and tail stages
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(pre_vld_reg) && $stable(mid_vld_reg) && $stable(tl_vld_reg))
        else $error("pipeline moved during stall");

    // an accepted beat lands in the first stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> pre_vld_reg[0])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

[dv/tb_barometer_pressure_compensation.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_barometer_pressure_compensation
// self-checking bench for the pressure compensation pipeline: calibration
// sets are loaded over apb, raw sample pairs are streamed in with random
// gaps, and every result beat is compared against a local integer predictor
// ----------------------------------------------------------------------------
module tb_barometer_pressure_compensation;

    localparam int LATENCY   = 82;
    localparam int WDOG_MAX  = 4000;

    // one compensated result
    typedef struct {
        logic signed [31:0] temp;
        logic signed [31:0] pres;
        logic               err;
    } comp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // raw_temperature[15:0], raw_pressure[34:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // temperature_tenths[31:0], pressure_pascal[63:32]
    logic        m_axis_tuser;   // divide_error

    barometer_pressure_compensation dut (.*);

    // predictor copy of the calibration registers
    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_quad, cal_temp;
    logic [1:0]  oss_set;

    logic [39:0] sample_q[$];    // raw pairs waiting for the driver
    comp_t       result_q[$];    // predicted results in arrival order
    int          errors;
    int          beats_in, beats_out, div_errs;
    int          wdog;
    int          src_gap, snk_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // truncating signed divide with wrap on min / -1
    function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
        if (b == -32'sd1)
            return -a;
        return a / b;
    endfunction

    function automatic logic signed [31:0] s16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // integer compensation of one raw pair with the current calibration
    function automatic comp_t compensate(logic [15:0] ut, logic [18:0] up);
        comp_t r;
        logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, den, b5, t, b6, sq, b3, p, q, sh;
        logic [31:0] ac4, b4, b7, pu;
        ac1 = s16(cal_a[47:32]);
        ac2 = s16(cal_a[31:16]);
        ac3 = s16(cal_a[15:0]);
        ac4 = {16'd0, cal_b[47:32]};
        ac5 = {16'd0, cal_b[31:16]};
        ac6 = {16'd0, cal_b[15:0]};
        b1  = s16(cal_quad[31:16]);
        b2  = s16(cal_quad[15:0]);
        mc  = s16(cal_temp[31:16]);
        md  = s16(cal_temp[15:0]);
        r.temp = 0;
        r.pres = 0;
        r.err  = 1'b1;
        x1  = tdiv(($signed({16'd0, ut}) - ac6) * ac5, 32768);
        den = x1 + md;
        if (den == 0)
            return r;
        x2 = tdiv(mc * 2048, den);
        b5 = x1 + x2;
        t  = tdiv(b5 + 8, 16);
        b6 = b5 - 4000;
        sq = tdiv(b6 * b6, 4096);
        x1 = tdiv(b2 * sq, 2048);
        x2 = tdiv(ac2 * b6, 2048);
        x3 = x1 + x2;
        sh = (ac1 * 4 + x3) <<< oss_set;
        b3 = tdiv(sh + 2, 4);
        x1 = tdiv(ac3 * b6, 8192);
        x2 = tdiv(b1 * sq, 65536);
        x3 = tdiv(x1 + x2 + 2, 4);
        b4 = (ac4 * 32'(x3 + 32768)) / 32'd32768;
        if (b4 == 0)
            return r;
        b7 = ({13'd0, up} - 32'(b3)) * (32'd50000 >> oss_set);
        // overflow guard on the pressure quotient
        if (b7 < 32'h8000_0000)
            pu = (b7 * 2) / b4;
        else
            pu = (b7 / b4) * 2;
        p  = pu;
        q  = tdiv(p, 256);
        x1 = tdiv((q * q) * 3038, 65536);
        x2 = tdiv(-32'sd7357 * p, 65536);
        p  = p + tdiv(x1 + x2 + 3791, 16);
        r.temp = t;
        r.pres = p;
        r.err  = 1'b0;
        return r;
    endfunction

    // apb write: setup then access, mirrored into the predictor
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'd0};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bpc_pkg::REG_CAL_A:    cal_a    = val[47:0];
            bpc_pkg::REG_CAL_B:    cal_b    = val[47:0];
            bpc_pkg::REG_CAL_QUAD: cal_quad = val[31:0];
            bpc_pkg::REG_CAL_TEMP: cal_temp = val[31:0];
            bpc_pkg::REG_OSS:      oss_set  = val[1:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(logic [47:0] a, logic [47:0] b, logic [31:0] qd,
                            logic [31:0] tp, logic [1:0] os);
        reg_write(bpc_pkg::REG_CAL_A, {16'd0, a});
        reg_write(bpc_pkg::REG_CAL_B, {16'd0, b});
        reg_write(bpc_pkg::REG_CAL_QUAD, {32'd0, qd});
        reg_write(bpc_pkg::REG_CAL_TEMP, {32'd0, tp});
        reg_write(bpc_pkg::REG_OSS, {62'd0, os});
    endtask

    // wait for the pipeline to drain, then let the tail settle
    task automatic drain();
        while (sample_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [39:0] pack_raw(logic [15:0] ut, logic [18:0] up);
        return {5'd0, up, ut};
    endfunction

    // sample driver: random gap before each beat, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[34:16]));
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    src_gap       <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        comp_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
            wdog          <= 0;
        end
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_out++;
                if (m_axis_tuser)
                    div_errs++;
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat data=%h err=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if ($signed(m_axis_tdata[31:0]) !== exp_r.temp)
                    begin
                        errors++;
                        $display("%0t: temperature exp %0d got %0d", $time, exp_r.temp,
                                 $signed(m_axis_tdata[31:0]));
                    end
                    if ($signed(m_axis_tdata[63:32]) !== exp_r.pres)
                    begin
                        errors++;
                        $display("%0t: pressure exp %0d got %0d", $time, exp_r.pres,
                                 $signed(m_axis_tdata[63:32]));
                    end
                    if (m_axis_tuser !== exp_r.err)
                    begin
                        errors++;
                        $display("%0t: divide_error exp %b got %b", $time, exp_r.err,
                                 m_axis_tuser);
                    end
                end
            end
            // stall-free stretches alternate with random stalls
            if (snk_gap > 0)
            begin
                snk_gap       <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready && $urandom_range(0, 2) != 0)
                    snk_gap <= $urandom_range(0, 14);
            end
            if (wdog >= WDOG_MAX)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // fully random 48-bit calibration group
    function automatic logic [47:0] rand48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    initial
    begin
        logic [15:0] ut;
        logic [18:0] up;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cal_a     = '0;
        cal_b     = '0;
        cal_quad  = '0;
        cal_temp  = '0;
        oss_set   = '0;
        errors    = 0;
        beats_in  = 0;
        beats_out = 0;
        div_errs  = 0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration: zero ac5 and md give the temperature divisor error
        sample_q.push_back(pack_raw(16'h1234, 19'h1234));
        drain();

        // datasheet-like calibration, field extremes
        load_cal({16'sd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                 {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd0);
        sample_q.push_back(pack_raw(16'd27898, 19'd23843));
        sample_q.push_back(pack_raw(16'h0000, 19'h00000));
        sample_q.push_back(pack_raw(16'hFFFF, 19'h7FFFF));
        sample_q.push_back(pack_raw(16'h0000, 19'h7FFFF));
        sample_q.push_back(pack_raw(16'hFFFF, 19'h00000));
        sample_q.push_back(pack_raw(16'h5555, 19'h2AAAA));
        sample_q.push_back(pack_raw(16'hAAAA, 19'h55555));
        drain();

        // zero temperature divisor: ac5 = 0 makes x1 = 0, md = 0
        load_cal({16'sd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd0, 16'd23153},
                 {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd0}, 2'd3);
        sample_q.push_back(pack_raw(16'd27898, 19'd23843));
        sample_q.push_back(pack_raw(16'hFFFF, 19'h7FFFF));
        drain();

        // all-ones and min-signed calibration extremes, oversampling 3 and 1
        load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_8000, 2'd3);
        sample_q.push_back(pack_raw(16'hFFFF, 19'h7FFFF));
        sample_q.push_back(pack_raw(16'h0000, 19'h00000));
        sample_q.push_back(pack_raw(16'h8000, 19'h40000));
        drain();
        load_cal(48'h8000_8000_8000, 48'h0001_8000_0000, 32'h8000_7FFF,
                 32'h8000_7FFF, 2'd1);
        sample_q.push_back(pack_raw(16'h7FFF, 19'h3FFFF));
        sample_q.push_back(pack_raw(16'h0001, 19'h00001));
        drain();

        // random calibration phases with mostly realistic words
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 3 == 2)
                load_cal(rand48(), rand48(), $urandom(), $urandom(), 2'($urandom_range(0, 3)));
            else
                load_cal({16'($urandom_range(0, 2000) - 1000 + 408),
                          16'($urandom_range(0, 400) - 200 - 72),
                          16'($urandom_range(0, 4000) - 2000 - 14383)},
                         {16'($urandom_range(30000, 36000)), 16'($urandom_range(24000, 34000)),
                          16'($urandom_range(15000, 26000))},
                         {16'($urandom_range(5000, 7000)), 16'($urandom_range(0, 300))},
                         {16'($urandom_range(0, 2000) - 1000 - 11786),
                          16'($urandom_range(2300, 3000))},
                         2'($urandom_range(0, 3)));
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    ut = 16'($urandom_range(20000, 36000));
                    up = 19'($urandom_range(15000, 30000) << oss_set);
                end
                else
                begin
                    ut = 16'($urandom());
                    up = 19'($urandom());
                end
                sample_q.push_back(pack_raw(ut, up));
            end
            // pause the sender on one phase until everything has returned
            if (ph == 5)
            begin
                while (sample_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
                    @(posedge clk);
                for (int i = 0; i < 20; i++)
                    sample_q.push_back(pack_raw(16'($urandom()), 19'($urandom())));
            end
            drain();
        end

        $display("covered %0d sample beats, %0d results, %0d with divide error",
                 beats_in, beats_out, div_errs);
        $display("calibration: reset, typical, extremes and 12 random sets, oss 0..3");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
